### src/round_robin_quantum_scheduler_defines.svh
// Assertion macros for the round-robin quantum scheduler.
// Included by the top level; no other dependencies.
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define RRQS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrqs: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define RRQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrqs: next-cycle check failed");
`else
`define RRQS_ASSERT_IMP(label, clk, rst, ante, cons)
`define RRQS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### src/rrqs_pkg.sv
// Shared types and constants of the round-robin quantum scheduler.
// No dependencies.
package rrqs_pkg;

  localparam int TABLE_DEPTH      = 16;
  localparam int PROCESS_ID_COUNT = 256;

  localparam int ID_W   = 8;
  localparam int OP_W   = 3;
  localparam int Q_W    = 8;
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W  = $clog2(TABLE_DEPTH + 2);
  localparam int BLK_AW = $clog2(PROCESS_ID_COUNT);
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [Q_W-1:0] QUANTUM_RESET = 8'd4;
  localparam logic           REG_QUANTUM   = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 3'd0,
    OP_ADMIT    = 3'd1,
    OP_FINISH   = 3'd2,
    OP_SCHEDULE = 3'd3,
    OP_BLOCK    = 3'd4,
    OP_UNBLOCK  = 3'd5
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic [ID_W-1:0] process_id;
  } sched_in_t;

  typedef struct packed {
    logic            granted;
    logic [ID_W-1:0] granted_id;
    logic            slice_expired;
    logic [ID_W-1:0] expired_id;
    logic            op_error;
  } sched_out_t;

  typedef struct packed {
    logic              wr;
    logic [BLK_AW-1:0] addr;
    logic              val;
  } blk_req_t;

endpackage

### src/round_robin_quantum_scheduler.sv
// Round-robin process scheduler with a time quantum: sequencer, id table, registers.
// Depends on rrqs_pkg, rrqs_block_mem and round_robin_quantum_scheduler_defines.svh.
//
//  channel   | handshake                        | payload
//  ----------+----------------------------------+---------------------------
//  command   | start, busy (taken: start & !busy)| cmd    (sched_in_t)
//  result    | done (one-cycle strobe)          | result (sched_out_t)
//  config    | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// Tick, admit, block, unblock and unused codes complete in the execute state;
// finish searches the table and moves each later entry down, and schedule scans
// it, each step bound by the single-port id table and the registered
// blocked-flag read on each scan step.
// After reset the blocked flags are cleared in a sweep over all PROCESS_ID_COUNT ids,
// with busy high; configuration writes are taken throughout.
// The receiver cannot stall: each result shows for exactly one cycle.
`include "round_robin_quantum_scheduler_defines.svh"

module round_robin_quantum_scheduler import rrqs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // command item
  input  logic              start,
  output logic              busy,
  input  sched_in_t         cmd,
  // result item
  output logic              done,
  output sched_out_t        result,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // One-hot sequencer states.
  typedef enum logic [9:0] {
    ST_CLEAR    = 10'b00_0000_0001,
    ST_IDLE     = 10'b00_0000_0010,
    ST_EXEC     = 10'b00_0000_0100,
    ST_FIND_RD  = 10'b00_0000_1000,
    ST_FIND_CMP = 10'b00_0001_0000,
    ST_MOVE_RD  = 10'b00_0010_0000,
    ST_MOVE_WR  = 10'b00_0100_0000,
    ST_SCAN_RD  = 10'b00_1000_0000,
    ST_SCAN_ID  = 10'b01_0000_0000,
    ST_SCAN_CHK = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  // Configuration register.
  logic [Q_W-1:0] quantum;

  // Latched command.
  op_t             op_q;
  logic [ID_W-1:0] pid_q;

  // Scheduler state.
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic [POS_W-1:0] scan_position, scan_position_next;
  logic             running_valid, running_valid_next;
  logic [ID_W-1:0]  running_id, running_id_next;
  logic [Q_W-1:0]   slice_left, slice_left_next;

  // Sequencer working registers.
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] tried, tried_next;
  logic [ID_W-1:0]  scan_id, scan_id_next;
  logic             scan_in_range, scan_in_range_next;

  // Result register.
  logic       done_next;
  sched_out_t result_next;

  // Id table: single write port, registered read.
  logic [ID_W-1:0]  ent_mem [TABLE_DEPTH];
  logic             ent_we;
  logic [IDX_W-1:0] ent_waddr;
  logic [ID_W-1:0]  ent_wdata;
  logic [IDX_W-1:0] ent_raddr;
  logic [ID_W-1:0]  ent_rdata;

  // Blocked-flag store.
  blk_req_t blk_req;
  logic     blk_rdata;
  logic     blk_clear_busy;

  logic             cfg_wr;
  logic [CNT_W-1:0] count_m1;
  logic [CNT_W-1:0] idx_inc;
  logic [POS_W-1:0] pos_eff;
  logic             pid_in_range;
  logic             scan_blocked;

  rrqs_block_mem u_block_mem (
    .clk        (clk),
    .rst        (rst),
    .req        (blk_req),
    .rd_data    (blk_rdata),
    .clear_busy (blk_clear_busy)
  );

  // ---------------------------------------------------------------------------
  // Configuration port: one register, always ready.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RESET;
    end else if (cfg_wr && (paddr[CFG_AW-1] == REG_QUANTUM)) begin
      quantum <= pwdata[Q_W-1:0];
    end
  end

  assign prdata = (paddr[CFG_AW-1] == REG_QUANTUM) ? CFG_DW'(quantum) : '0;

  // ---------------------------------------------------------------------------
  // Id table memory.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata <= ent_mem[ent_raddr];
  end

  // ---------------------------------------------------------------------------
  // Shared helpers for the sequencer.
  // ---------------------------------------------------------------------------
  assign busy         = (state != ST_IDLE);
  assign count_m1     = entry_count - 1'b1;
  assign idx_inc      = idx + 1'b1;
  // Wrap the scan position once it reaches the fill.
  assign pos_eff      = (scan_position >= POS_W'(entry_count)) ? '0 : scan_position;
  // Ids at or above the id space are never blocked.
  assign pid_in_range = (32'(pid_q) < 32'(PROCESS_ID_COUNT));
  assign scan_blocked = scan_in_range && blk_rdata;

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next         = state;
    entry_count_next   = entry_count;
    scan_position_next = scan_position;
    running_valid_next = running_valid;
    running_id_next    = running_id;
    slice_left_next    = slice_left;
    idx_next           = idx;
    tried_next         = tried;
    scan_id_next       = scan_id;
    scan_in_range_next = scan_in_range;
    done_next          = 1'b0;
    result_next        = '0;

    ent_we    = 1'b0;
    ent_waddr = entry_count[IDX_W-1:0];
    ent_wdata = pid_q;
    ent_raddr = idx[IDX_W-1:0];

    blk_req.wr   = 1'b0;
    blk_req.addr = BLK_AW'(pid_q);
    blk_req.val  = (op_q == OP_BLOCK);

    unique case (state)
      ST_CLEAR: begin
        // Hold off items until every blocked flag is cleared.
        if (!blk_clear_busy) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_next = ST_IDLE;
        done_next  = 1'b1;
        unique case (op_q)
          OP_TICK: begin
            // Count the slice down; a slice of zero or one expires now.
            if (running_valid) begin
              if (slice_left <= Q_W'(1)) begin
                slice_left_next           = '0;
                running_valid_next        = 1'b0;
                result_next.slice_expired = 1'b1;
                result_next.expired_id    = running_id;
              end else begin
                slice_left_next = slice_left - 1'b1;
              end
            end
          end
          OP_ADMIT: begin
            // Append, or flag a full table.
            if (entry_count >= CNT_W'(TABLE_DEPTH)) begin
              result_next.op_error = 1'b1;
            end else begin
              ent_we           = 1'b1;
              entry_count_next = entry_count + 1'b1;
            end
          end
          OP_FINISH: begin
            if (entry_count == '0) begin
              result_next.op_error = 1'b1;
            end else begin
              idx_next   = '0;
              state_next = ST_FIND_RD;
              done_next  = 1'b0;
            end
          end
          OP_SCHEDULE: begin
            // An empty table grants nothing and leaves the position alone.
            if (entry_count != '0) begin
              tried_next = '0;
              state_next = ST_SCAN_RD;
              done_next  = 1'b0;
            end
          end
          OP_BLOCK, OP_UNBLOCK: begin
            blk_req.wr = pid_in_range;
          end
          default: begin
          end
        endcase
      end

      // Search the table for the first copy of the id.
      ST_FIND_RD: begin
        state_next = ST_FIND_CMP;
      end

      ST_FIND_CMP: begin
        if (ent_rdata == pid_q) begin
          if (idx < count_m1) begin
            state_next = ST_MOVE_RD;
          end else begin
            entry_count_next = count_m1;
            state_next       = ST_IDLE;
            done_next        = 1'b1;
          end
        end else if (idx == count_m1) begin
          result_next.op_error = 1'b1;
          state_next           = ST_IDLE;
          done_next            = 1'b1;
        end else begin
          idx_next   = idx_inc;
          state_next = ST_FIND_RD;
        end
      end

      // Close the gap: move each later entry down by one.
      ST_MOVE_RD: begin
        ent_raddr  = idx_inc[IDX_W-1:0];
        state_next = ST_MOVE_WR;
      end

      ST_MOVE_WR: begin
        ent_we    = 1'b1;
        ent_waddr = idx[IDX_W-1:0];
        ent_wdata = ent_rdata;
        idx_next  = idx_inc;
        if (idx_inc == count_m1) begin
          entry_count_next = count_m1;
          state_next       = ST_IDLE;
          done_next        = 1'b1;
        end else begin
          state_next = ST_MOVE_RD;
        end
      end

      // Scan: read the entry at the wrapped position.
      ST_SCAN_RD: begin
        scan_position_next = pos_eff;
        ent_raddr          = pos_eff[IDX_W-1:0];
        state_next         = ST_SCAN_ID;
      end

      // Look up the blocked flag of the entry just read.
      ST_SCAN_ID: begin
        blk_req.addr       = BLK_AW'(ent_rdata);
        scan_id_next       = ent_rdata;
        scan_in_range_next = (32'(ent_rdata) < 32'(PROCESS_ID_COUNT));
        state_next         = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        if (!scan_blocked) begin
          // Grant: the new process runs with a full slice.
          running_valid_next     = 1'b1;
          running_id_next        = scan_id;
          slice_left_next        = quantum;
          scan_position_next     = scan_position + 1'b1;
          result_next.granted    = 1'b1;
          result_next.granted_id = scan_id;
          state_next             = ST_IDLE;
          done_next              = 1'b1;
        end else if (tried == count_m1) begin
          // Every entry tried: advance once for this entry and once more.
          scan_position_next = scan_position + POS_W'(2);
          state_next         = ST_IDLE;
          done_next          = 1'b1;
        end else begin
          scan_position_next = scan_position + 1'b1;
          tried_next         = tried + 1'b1;
          state_next         = ST_SCAN_RD;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      entry_count   <= '0;
      scan_position <= '0;
      running_valid <= 1'b0;
      running_id    <= '0;
      slice_left    <= '0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      entry_count   <= entry_count_next;
      scan_position <= scan_position_next;
      running_valid <= running_valid_next;
      running_id    <= running_id_next;
      slice_left    <= slice_left_next;
      done          <= done_next;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_q  <= op_t'(cmd.opcode);
      pid_q <= cmd.process_id;
    end
    idx           <= idx_next;
    tried         <= tried_next;
    scan_id       <= scan_id_next;
    scan_in_range <= scan_in_range_next;
    result        <= result_next;
  end

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  `RRQS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `RRQS_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `RRQS_ASSERT_IMP(a_grant_xor_expire, clk, rst, done, !(result.granted && result.slice_expired))
  `RRQS_ASSERT_IMP(a_grant_running, clk, rst, done && result.granted, running_valid)
  `RRQS_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, entry_count <= CNT_W'(TABLE_DEPTH))

endmodule

### src/rrqs_block_mem.sv
// Blocked-flag store, one bit per process id, with a clearing sweep after reset.
// Depends on rrqs_pkg.
module rrqs_block_mem import rrqs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  blk_req_t req,
  output logic     rd_data,
  output logic     clear_busy
);

  logic              mem [PROCESS_ID_COUNT];
  logic [BLK_AW-1:0] clr_addr;

  // Sweep one entry per cycle until every flag is cleared.
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clr_addr   <= '0;
    end else if (clear_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == BLK_AW'(PROCESS_ID_COUNT - 1)) begin
        clear_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear_busy) begin
      mem[clr_addr] <= 1'b0;
    end else if (req.wr) begin
      mem[req.addr] <= req.val;
    end
    rd_data <= mem[req.addr];
  end

endmodule
